// File: hw/rtl/maf_pkg.sv
// Shared types, constants and helpers for the moving-average filter.
// No dependencies; used by every other file of the block but maf_ram.
`timescale 1ns / 1ps

package maf_pkg;

  localparam int unsigned MaxWindow = 64;
  localparam int unsigned SlotW     = $clog2(MaxWindow);
  localparam int unsigned CntW      = $clog2(MaxWindow + 1);
  localparam int unsigned SampleW   = 16;
  localparam int unsigned SumW      = SampleW + SlotW;
  localparam int unsigned QuoCntW   = $clog2(SumW + 1);
  localparam int unsigned WinRegW   = 7;

  localparam logic [WinRegW-1:0] WindowReset = WinRegW'(8);

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FETCH  = 5'b00010,
    ST_START  = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  // request to the divider
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

  // window size as written: 0 -> 1, above the store depth -> store depth
  function automatic logic [CntW-1:0] limit_size(input logic [WinRegW-1:0] v);
    logic [CntW-1:0] r;
    if (v == '0) begin
      r = CntW'(1);
    end else if (32'(v) > MaxWindow) begin
      r = CntW'(MaxWindow);
    end else begin
      r = CntW'(v);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/maf_if.sv
// Valid/ready channel interfaces for the moving-average filter.
// Depends on maf_pkg for field widths.
`timescale 1ns / 1ps

interface maf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [maf_pkg::SampleW-1:0]  sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface maf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [maf_pkg::SampleW-1:0]  average;
  logic                                window_full;

  modport source (output valid, output average, output window_full, input ready);
  modport sink   (input valid, input average, input window_full, output ready);
endinterface

// File: hw/rtl/maf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module maf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hw/rtl/maf_div.sv
// Iterative restoring divider: unsigned sum magnitude by sample count,
// one quotient bit per cycle. Depends on maf_pkg.
`timescale 1ns / 1ps

module maf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  maf_pkg::div_req_t req_i,
  output maf_pkg::div_rsp_t rsp_o
);

  logic [maf_pkg::CntW-1:0]    rem_q, rem_d;
  logic [maf_pkg::SumW-1:0]    quo_q, quo_d;
  logic [maf_pkg::CntW-1:0]    dvs_q;
  logic [maf_pkg::QuoCntW-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [maf_pkg::CntW:0]      rem_sh;
  logic                        ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[maf_pkg::SumW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? maf_pkg::CntW'(rem_sh - {1'b0, dvs_q}) : maf_pkg::CntW'(rem_sh);
    quo_d  = {quo_q[maf_pkg::SumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= maf_pkg::QuoCntW'(maf_pkg::SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == maf_pkg::QuoCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: hw/rtl/moving_average_filter_top.sv
// Boxcar moving-average filter, top level.
// Depends on maf_pkg, maf_if, maf_ram and maf_div.
`timescale 1ns / 1ps
//
// Usage:
//   in_i carries requests: operation (push or clear) and a signed 16-bit
//   sample. out_o returns one result per request: the signed average of
//   the samples held (truncated toward zero) and window_full.
//   cfg_we_i/cfg_wdata_i write the window size (0 reads as 1, above 64
//   as 64); every write empties the window. Write only while idle.
// Sequence:
//   A push runs from acceptance to result as follows: the ring store is
//   read at acceptance, then the sum is updated, the divider is loaded,
//   the bit-serial divider runs, the quotient is taken and the output
//   register is loaded. A clear skips the divider and goes straight to
//   the output register. in_i.ready is high only while no request is in
//   work, so a new request is taken only once the last one is through.
// Reset:
//   Window empty, window size 8, no result pending. The ring store is
//   not cleared; only slots written since the last clear are ever read.
// Stall:
//   Results sit in an output register. A new request is accepted while
//   a result waits; the next result waits in the last step until the
//   output register is taken.

module moving_average_filter_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [maf_pkg::WinRegW-1:0] cfg_wdata_i,
  maf_in_if.sink                      in_i,
  maf_out_if.source                   out_o
);

  maf_pkg::state_e state_q, state_d;

  logic [maf_pkg::CntW-1:0]           window_q;
  logic [maf_pkg::CntW-1:0]           held_q;
  logic [maf_pkg::SlotW-1:0]          wslot_q;
  logic signed [maf_pkg::SumW-1:0]    sum_q;
  logic [maf_pkg::SlotW-1:0]          slot_q;
  logic signed [maf_pkg::SampleW-1:0] x_q;
  logic                               neg_q;
  logic                               full_q;
  logic signed [maf_pkg::SampleW-1:0] avg_q;

  logic                               out_valid_q;
  logic signed [maf_pkg::SampleW-1:0] out_avg_q;
  logic                               out_full_q;

  logic                               in_acc;
  logic                               out_load;
  logic [maf_pkg::SlotW-1:0]          rd_slot;
  logic [maf_pkg::SampleW-1:0]        old_sample;
  logic                               was_full;
  logic [maf_pkg::CntW-1:0]           held_next;
  logic [maf_pkg::CntW-1:0]           slot_inc;
  logic signed [maf_pkg::SumW-1:0]    sum_next;
  logic [maf_pkg::SampleW-1:0]        quo_lo;

  maf_pkg::div_req_t div_req;
  maf_pkg::div_rsp_t div_rsp;

  assign in_i.ready = (state_q == maf_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // slot index wraps when the window shrank below it
  assign rd_slot = (maf_pkg::CntW'(wslot_q) >= window_q) ? '0 : wslot_q;

  maf_ram #(
    .Width(maf_pkg::SampleW),
    .Depth(maf_pkg::MaxWindow)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (state_q == maf_pkg::ST_FETCH),
    .waddr_i(slot_q),
    .wdata_i(x_q),
    .raddr_i(rd_slot),
    .rdata_o(old_sample)
  );

  always_comb begin
    was_full  = (held_q == window_q);
    held_next = was_full ? held_q : held_q + 1'b1;
    sum_next  = sum_q + maf_pkg::SumW'(x_q)
              - (was_full ? maf_pkg::SumW'($signed(old_sample)) : '0);
    slot_inc  = maf_pkg::CntW'(slot_q) + 1'b1;
  end

  assign div_req.start    = (state_q == maf_pkg::ST_START);
  assign div_req.dividend = sum_q[maf_pkg::SumW-1] ? maf_pkg::SumW'(-sum_q)
                                                   : maf_pkg::SumW'(sum_q);
  assign div_req.divisor  = held_q;

  maf_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign quo_lo   = div_rsp.quotient[maf_pkg::SampleW-1:0];
  assign out_load = (state_q == maf_pkg::ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      maf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_i.operation == maf_pkg::OP_CLEAR) ? maf_pkg::ST_DONE
                                                           : maf_pkg::ST_FETCH;
        end
      end
      maf_pkg::ST_FETCH:  state_d = maf_pkg::ST_START;
      maf_pkg::ST_START:  state_d = maf_pkg::ST_DIVIDE;
      maf_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_d = maf_pkg::ST_DONE;
        end
      end
      maf_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = maf_pkg::ST_IDLE;
        end
      end
      default: state_d = maf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= maf_pkg::ST_IDLE;
      window_q    <= maf_pkg::limit_size(maf_pkg::WindowReset);
      held_q      <= '0;
      wslot_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        window_q <= maf_pkg::limit_size(cfg_wdata_i);
        held_q   <= '0;
        wslot_q  <= '0;
        sum_q    <= '0;
      end else if (in_acc && in_i.operation == maf_pkg::OP_CLEAR) begin
        held_q  <= '0;
        wslot_q <= '0;
        sum_q   <= '0;
      end else if (state_q == maf_pkg::ST_FETCH) begin
        held_q  <= held_next;
        sum_q   <= sum_next;
        wslot_q <= (slot_inc >= window_q) ? '0 : slot_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= in_i.sample;
      slot_q <= rd_slot;
      avg_q  <= '0;
      full_q <= 1'b0;
    end
    if (state_q == maf_pkg::ST_FETCH) begin
      full_q <= (held_next == window_q);
    end
    if (state_q == maf_pkg::ST_START) begin
      neg_q <= sum_q[maf_pkg::SumW-1];
    end
    if (state_q == maf_pkg::ST_DIVIDE && div_rsp.done) begin
      avg_q <= neg_q ? $signed(-quo_lo) : $signed(quo_lo);
    end
    if (out_load) begin
      out_avg_q  <= avg_q;
      out_full_q <= full_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.average     = out_avg_q;
  assign out_o.window_full = out_full_q;

endmodule

// File: hw/rtl/maf_checker.sv
// Port-level checks for the moving-average filter, bound to the top level.
// Depends on maf_pkg for field widths.
`timescale 1ns / 1ps

module maf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               in_operation_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [maf_pkg::SampleW-1:0] out_average_i,
  input logic                               out_window_full_i
);

  // a held result does not change while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_average_i)
                                    && $stable(out_window_full_i))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while busy");

  // a push needs the divider; the input side is still busy while it is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_operation_i == maf_pkg::OP_PUSH |-> ##2 !in_ready_i)
    else $error("push finished too early");

  // a fresh result frees the input side in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $rose(in_ready_i))
    else $error("result appeared without finishing a request");

endmodule

bind moving_average_filter_top maf_checker u_maf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_operation_i   (in_i.operation),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_average_i    (out_o.average),
  .out_window_full_i(out_o.window_full)
);

// File: tb/sv/moving_average_filter_top_tb.sv
// Self-checking testbench for moving_average_filter_top: directed and random requests,
// window size writes, and random back-pressure.
// Depends on maf_pkg and maf_if from the RTL.
`timescale 1ns / 1ps

module moving_average_filter_top_tb;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned MaxReports = 40;

  typedef logic signed [maf_pkg::SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t average;
    logic    window_full;
  } avg_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [maf_pkg::WinRegW-1:0] cfg_wdata_i;

  maf_in_if  in_if();
  maf_out_if out_if();

  moving_average_filter_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // filter state as the predictor sees it
  sample_t     sample_hist [maf_pkg::MaxWindow];
  int          hist_slot;
  int          hist_count;
  int          hist_sum;
  int          win_len;
  avg_result_t avg_expect_q[$];

  bit          idle_enable;
  int          errors;
  int          n_pushes;
  int          n_clears;
  int          n_results;
  int          n_cfg_writes;
  int          quiet_cycles;
  avg_result_t head;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int clamp_window(logic [maf_pkg::WinRegW-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > int'(maf_pkg::MaxWindow)) begin
      return maf_pkg::MaxWindow;
    end
    return int'(v);
  endfunction

  function automatic void empty_history();
    hist_slot  = 0;
    hist_count = 0;
    hist_sum   = 0;
  endfunction

  function automatic void predict_average(maf_pkg::op_e op, sample_t s);
    avg_result_t r;
    int          slot;
    r = '0;
    if (op == maf_pkg::OP_CLEAR) begin
      empty_history();
    end else begin
      slot = hist_slot;
      if (slot >= win_len) begin
        slot = 0;
      end
      if (hist_count < win_len) begin
        hist_count++;
      end else begin
        hist_sum -= int'(sample_hist[slot]);
      end
      sample_hist[slot] = s;
      hist_sum += int'(s);
      slot++;
      if (slot >= win_len) begin
        slot = 0;
      end
      hist_slot = slot;
      // SV signed division truncates toward zero
      r.average     = sample_t'(hist_sum / hist_count);
      r.window_full = (hist_count == win_len);
    end
    avg_expect_q.push_back(r);
  endfunction

  // one request on in_if; prediction is taken at the accepting edge
  task automatic send_request(maf_pkg::op_e op, sample_t s);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.operation = op;
    in_if.sample    = s;
    do @(posedge clk_i); while (!in_if.ready);
    predict_average(op, s);
    if (op == maf_pkg::OP_CLEAR) n_clears++;
    else n_pushes++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic push_sample(sample_t s);
    send_request(maf_pkg::OP_PUSH, s);
  endtask

  task automatic wait_drained();
    while (avg_expect_q.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_window(logic [maf_pkg::WinRegW-1:0] v);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    win_len  = clamp_window(v);
    empty_history();
    n_cfg_writes++;
    @(negedge clk_i);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(16'h7FFF);
      1:       return sample_t'(16'h8000);
      2:       return sample_t'($urandom_range(0, 7)) - sample_t'(4);
      default: return sample_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // mostly pushes, an occasional clear carrying a junk sample
  task automatic random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        send_request(maf_pkg::OP_CLEAR, sample_t'($urandom_range(0, 16'hFFFF)));
      end else begin
        push_sample(random_sample());
      end
    end
  endtask

  // extremes at reset window size, wrap-around, truncation toward zero, clear
  task automatic test_directed_extremes();
    for (int i = 0; i < 9; i++) push_sample(sample_t'(16'h7FFF));
    for (int i = 0; i < 8; i++) push_sample(sample_t'(16'h8000));
    push_sample(sample_t'(-1));
    send_request(maf_pkg::OP_CLEAR, sample_t'(16'h7FFF));
    push_sample(sample_t'(-3));
    push_sample(sample_t'(2));
    push_sample(sample_t'(-2));
    send_request(maf_pkg::OP_CLEAR, sample_t'(16'h8000));
    push_sample(sample_t'(1));
  endtask

  // zero reads as 1, above 64 saturates, and both ends of the legal range
  task automatic test_window_limits();
    write_window(7'd0);
    for (int i = 0; i < 4; i++) push_sample(random_sample());
    write_window(7'd127);
    for (int i = 0; i < 70; i++) push_sample(sample_t'(16'h8000));
    write_window(7'd64);
    random_traffic(70);
    write_window(7'd1);
    random_traffic(10);
  endtask

  // shrink the window after a partial fill so old slots stay stale
  task automatic test_stale_slots();
    write_window(7'd64);
    random_traffic(40);
    write_window(7'd5);
    for (int i = 0; i < 12; i++) push_sample(random_sample());
    send_request(maf_pkg::OP_CLEAR, '0);
    for (int i = 0; i < 7; i++) push_sample(random_sample());
  endtask

  task automatic test_random_windows();
    logic [maf_pkg::WinRegW-1:0] sizes[6];
    sizes = '{7'd2, 7'd3, 7'd8, 7'd100, maf_pkg::WinRegW'($urandom_range(0, 127)), 7'd63};
    foreach (sizes[k]) begin
      write_window(sizes[k]);
      random_traffic(50);
    end
    // closing stretch with no idling on either side
    idle_enable = 1'b0;
    write_window(maf_pkg::WinRegW'($urandom_range(1, 64)));
    random_traffic(80);
  endtask

  // output back-pressure in random bursts
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready = 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(0, 14);
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      n_results++;
      if (avg_expect_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: unexpected result average=%0d window_full=%0b", $time,
                   out_if.average, out_if.window_full);
        end
      end else begin
        head = avg_expect_q.pop_front();
        if (out_if.average !== head.average) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("%0t: average mismatch expected %0d actual %0d", $time,
                     head.average, out_if.average);
          end
        end
        if (out_if.window_full !== head.window_full) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("%0t: window_full mismatch expected %0b actual %0b", $time,
                     head.window_full, out_if.window_full);
          end
        end
      end
    end
  end

  // watchdog: cycles in which no request moves on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == IdleLimit) begin
        $display("%0t: timeout, no request moved for %0d cycles", $time, IdleLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_if.valid     = 1'b0;
    in_if.operation = maf_pkg::OP_PUSH;
    in_if.sample    = '0;
    idle_enable     = 1'b1;
    errors          = 0;
    n_pushes        = 0;
    n_clears        = 0;
    n_results       = 0;
    n_cfg_writes    = 0;
    quiet_cycles    = 0;
    foreach (sample_hist[k]) sample_hist[k] = '0;
    win_len = clamp_window(maf_pkg::WindowReset);
    empty_history();

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_extremes();
    test_window_limits();
    test_stale_slots();
    test_random_windows();

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (avg_expect_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, avg_expect_q.size());
    end

    $display("Covered %0d pushes and %0d clears over %0d window size writes,",
             n_pushes, n_clears, n_cfg_writes);
    $display("with %0d results checked under random idle and back-pressure.", n_results);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
